// File: src/clh_pkg.sv
package clh_pkg;

  localparam int TICK_BITS     = 32;
  localparam int BACKOFF_STEPS = 6;
  localparam int CFG_BITS      = 16;
  localparam int COUNT_BITS    = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] BACKOFF_LAST = 3'(BACKOFF_STEPS - 1);

  // action codes on the input channel
  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_ERROR = 2'd1,
    ACT_POLL  = 2'd2
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEGRADED_QUIET = 2'd0,
    REG_DEGRADED_RX    = 2'd1,
    REG_PROBE_RX       = 2'd2,
    REG_PROBE_QUIET    = 2'd3
  } reg_index_t;

  // classified event as it travels from front to back
  typedef struct packed {
    action_t               kind;
    logic [TICK_BITS-1:0]  tick;
    logic                  bus_off;
    logic                  err_passive;
  } item_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // recovery backoff in ticks, saturating at the longest entry
  function automatic logic [TICK_BITS-1:0] backoff_ticks(input logic [2:0] step);
    logic [TICK_BITS-1:0] ticks;
    case (step)
      3'd0:    ticks = TICK_BITS'(25);
      3'd1:    ticks = TICK_BITS'(50);
      3'd2:    ticks = TICK_BITS'(100);
      3'd3:    ticks = TICK_BITS'(200);
      3'd4:    ticks = TICK_BITS'(500);
      default: ticks = TICK_BITS'(1000);
    endcase
    return ticks;
  endfunction

endpackage

// File: src/clh_front.sv
module clh_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [clh_pkg::TICK_BITS-1:0] tick,
  input  logic                          bus_off_event,
  input  logic                          err_passive_event,
  input  logic                          q_full,
  output logic                          push,
  output clh_pkg::item_t                push_item
);

  logic keep;

  assign in_ready = !q_full;

  // unknown actions and error events with no flag change nothing: drop them here
  always_comb begin
    case (action)
      clh_pkg::ACT_FRAME: keep = 1'b1;
      clh_pkg::ACT_ERROR: keep = bus_off_event || err_passive_event;
      clh_pkg::ACT_POLL:  keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign push                  = in_valid && in_ready && keep;
  assign push_item.kind        = clh_pkg::action_t'(action);
  assign push_item.tick        = tick;
  assign push_item.bus_off     = bus_off_event;
  assign push_item.err_passive = err_passive_event;

endmodule

// File: src/clh_queue.sv
module clh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clh_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output clh_pkg::head_t head
);

  clh_pkg::item_t                       entries [clh_pkg::QUEUE_DEPTH];
  logic [clh_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [clh_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [clh_pkg::QUEUE_PTR_BITS:0]     count;

  assign full       = count == (clh_pkg::QUEUE_PTR_BITS+1)'(clh_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/clh_back.sv
module clh_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [clh_pkg::CFG_BITS-1:0]   cfg_data,
  input  clh_pkg::head_t                 head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     link_state,
  output logic                           tx_enable,
  output logic                           release_init,
  output logic [clh_pkg::COUNT_BITS-1:0] bus_off_total,
  output logic [clh_pkg::COUNT_BITS-1:0] err_passive_total,
  output logic [2:0]                     backoff_index
);

  typedef enum logic [2:0] {
    MODE_UP           = 3'd0,
    MODE_DEGRADED     = 3'd1,
    MODE_BUS_OFF      = 3'd2,
    MODE_RECOVER_WAIT = 3'd3,
    MODE_PROBE        = 3'd4
  } mode_t;

  logic [clh_pkg::CFG_BITS-1:0]   degraded_quiet_ticks;
  logic [clh_pkg::CFG_BITS-1:0]   degraded_rx_window;
  logic [clh_pkg::CFG_BITS-1:0]   probe_rx_window;
  logic [clh_pkg::CFG_BITS-1:0]   probe_quiet_ticks;

  mode_t                          link_mode, link_mode_next;
  logic                           tx_allowed, tx_allowed_next;
  logic                           pending_bus_off, pending_bus_off_next;
  logic                           pending_err_passive, pending_err_passive_next;
  logic [clh_pkg::TICK_BITS-1:0]  last_rx_time, last_rx_time_next;
  logic [clh_pkg::TICK_BITS-1:0]  last_error_time, last_error_time_next;
  logic [clh_pkg::TICK_BITS-1:0]  recover_deadline, recover_deadline_next;
  logic [2:0]                     backoff_step, backoff_step_next;
  logic [clh_pkg::COUNT_BITS-1:0] bus_off_tally, bus_off_tally_next;
  logic [clh_pkg::COUNT_BITS-1:0] err_passive_tally, err_passive_tally_next;
  logic                           release_next;

  logic                           out_free;
  logic                           is_poll;
  logic [clh_pkg::TICK_BITS-1:0]  now;
  logic [clh_pkg::TICK_BITS-1:0]  err_age;
  logic [clh_pkg::TICK_BITS-1:0]  rx_age;

  assign out_free = !out_valid || out_ready;
  assign is_poll  = head.item.kind == clh_pkg::ACT_POLL;
  // frames and error events never wait for the output side
  assign pop      = head.valid && (!is_poll || out_free);
  assign now      = head.item.tick;
  assign rx_age   = now - last_rx_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      degraded_quiet_ticks <= clh_pkg::CFG_BITS'(500);
      degraded_rx_window   <= clh_pkg::CFG_BITS'(500);
      probe_rx_window      <= clh_pkg::CFG_BITS'(50);
      probe_quiet_ticks    <= clh_pkg::CFG_BITS'(100);
    end else if (cfg_write) begin
      case (cfg_index)
        clh_pkg::REG_DEGRADED_QUIET: degraded_quiet_ticks <= cfg_data;
        clh_pkg::REG_DEGRADED_RX:    degraded_rx_window   <= cfg_data;
        clh_pkg::REG_PROBE_RX:       probe_rx_window      <= cfg_data;
        clh_pkg::REG_PROBE_QUIET:    probe_quiet_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    link_mode_next           = link_mode;
    tx_allowed_next          = tx_allowed;
    pending_bus_off_next     = pending_bus_off;
    pending_err_passive_next = pending_err_passive;
    last_rx_time_next        = last_rx_time;
    last_error_time_next     = last_error_time;
    recover_deadline_next    = recover_deadline;
    backoff_step_next        = backoff_step;
    bus_off_tally_next       = bus_off_tally;
    err_passive_tally_next   = err_passive_tally;
    release_next             = 1'b0;
    err_age                  = '0;

    if (pop) begin
      case (head.item.kind)
        clh_pkg::ACT_FRAME: begin
          last_rx_time_next = now;
        end
        clh_pkg::ACT_ERROR: begin
          pending_bus_off_next     = pending_bus_off || head.item.bus_off;
          pending_err_passive_next = pending_err_passive || head.item.err_passive;
        end
        clh_pkg::ACT_POLL: begin
          // consume latched flags, bus-off first
          if (pending_bus_off) begin
            bus_off_tally_next   = bus_off_tally + 1'b1;
            last_error_time_next = now;
            tx_allowed_next      = 1'b0;
            link_mode_next       = MODE_BUS_OFF;
          end else if (pending_err_passive) begin
            err_passive_tally_next = err_passive_tally + 1'b1;
            last_error_time_next   = now;
            if (link_mode == MODE_UP) begin
              link_mode_next = MODE_DEGRADED;
            end
          end
          pending_bus_off_next     = 1'b0;
          pending_err_passive_next = 1'b0;
          err_age                  = now - last_error_time_next;

          // one step of the link state machine
          case (link_mode_next)
            MODE_UP: begin
              tx_allowed_next = 1'b1;
            end
            MODE_DEGRADED: begin
              tx_allowed_next = 1'b1;
              if (err_age > clh_pkg::TICK_BITS'(degraded_quiet_ticks) &&
                  rx_age < clh_pkg::TICK_BITS'(degraded_rx_window)) begin
                link_mode_next = MODE_UP;
              end
            end
            MODE_BUS_OFF: begin
              recover_deadline_next = now + clh_pkg::backoff_ticks(backoff_step);
              if (backoff_step < clh_pkg::BACKOFF_LAST) begin
                backoff_step_next = backoff_step + 1'b1;
              end
              link_mode_next = MODE_RECOVER_WAIT;
            end
            MODE_RECOVER_WAIT: begin
              tx_allowed_next = 1'b0;
              // plain compare, no wrap handling
              if (now >= recover_deadline) begin
                release_next         = 1'b1;
                link_mode_next       = MODE_PROBE;
                last_error_time_next = now;
              end
            end
            MODE_PROBE: begin
              tx_allowed_next = 1'b0;
              if (rx_age < clh_pkg::TICK_BITS'(probe_rx_window) ||
                  err_age > clh_pkg::TICK_BITS'(probe_quiet_ticks)) begin
                link_mode_next    = MODE_UP;
                tx_allowed_next   = 1'b1;
                backoff_step_next = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode           <= MODE_UP;
      tx_allowed          <= 1'b0;
      pending_bus_off     <= 1'b0;
      pending_err_passive <= 1'b0;
      last_rx_time        <= '0;
      last_error_time     <= '0;
      recover_deadline    <= '0;
      backoff_step        <= '0;
      bus_off_tally       <= '0;
      err_passive_tally   <= '0;
      out_valid           <= 1'b0;
    end else begin
      link_mode           <= link_mode_next;
      tx_allowed          <= tx_allowed_next;
      pending_bus_off     <= pending_bus_off_next;
      pending_err_passive <= pending_err_passive_next;
      last_rx_time        <= last_rx_time_next;
      last_error_time     <= last_error_time_next;
      recover_deadline    <= recover_deadline_next;
      backoff_step        <= backoff_step_next;
      bus_off_tally       <= bus_off_tally_next;
      err_passive_tally   <= err_passive_tally_next;
      // result register, loaded only by a poll
      if (pop && is_poll) begin
        out_valid         <= 1'b1;
        link_state        <= link_mode_next;
        tx_enable         <= tx_allowed_next;
        release_init      <= release_next;
        bus_off_total     <= bus_off_tally_next;
        err_passive_total <= err_passive_tally_next;
        backoff_index     <= backoff_step_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_backoff_saturates: assert property (@(posedge clk) disable iff (rst)
    backoff_step <= clh_pkg::BACKOFF_LAST)
    else $error("backoff step past last table entry");

  a_release_enters_probe: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_init |-> link_state == MODE_PROBE)
    else $error("release pulse without probe state");

  a_no_tx_in_recovery: assert property (@(posedge clk) disable iff (rst)
    out_valid && (link_state == MODE_RECOVER_WAIT || link_state == MODE_PROBE)
    |-> !tx_enable)
    else $error("tx enabled during recovery");

  a_bus_off_counted: assert property (@(posedge clk) disable iff (rst)
    pop && is_poll && pending_bus_off |=> bus_off_tally == $past(bus_off_tally) + 1'b1)
    else $error("bus-off poll not counted");

endmodule

// File: src/can_link_health_recovery_fsm.sv
// path: a poll is queued, popped at the head once the output is free, then registered
// throughput: one event per cycle while the queue has room; a 4-entry queue between
//   classifier and state logic absorbs output stalls, and frame/error events drain
//   even while a result waits
// reset: synchronous active-high rst returns the link to up with tx off, clears
//   latched flags, times, backoff step and counters, and loads register defaults
module can_link_health_recovery_fsm (
  input  logic                           clk,
  input  logic                           rst,

  // configuration write port
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [clh_pkg::CFG_BITS-1:0]   cfg_data,

  // event channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     action,
  input  logic [clh_pkg::TICK_BITS-1:0]  tick,
  input  logic                           bus_off_event,
  input  logic                           err_passive_event,

  // poll result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     link_state,
  output logic                           tx_enable,
  output logic                           release_init,
  output logic [clh_pkg::COUNT_BITS-1:0] bus_off_total,
  output logic [clh_pkg::COUNT_BITS-1:0] err_passive_total,
  output logic [2:0]                     backoff_index
);

  // front to queue
  logic           q_full;
  logic           push;
  clh_pkg::item_t push_item;

  // queue to back
  logic           pop;
  clh_pkg::head_t head;

  // classifier: takes every transfer while the queue has room, drops no-op events
  clh_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .tick              (tick),
    .bus_off_event     (bus_off_event),
    .err_passive_event (err_passive_event),
    .q_full            (q_full),
    .push              (push),
    .push_item         (push_item)
  );

  // short queue so the front keeps accepting while a poll result is stalled
  clh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  // link state machine, counters and result register
  clh_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .link_state        (link_state),
    .tx_enable         (tx_enable),
    .release_init      (release_init),
    .bus_off_total     (bus_off_total),
    .err_passive_total (err_passive_total),
    .backoff_index     (backoff_index)
  );

endmodule

// File: tb/tb_can_link_health_recovery_fsm.sv
module tb_can_link_health_recovery_fsm;

  // link modes as the result channel reports them
  typedef enum logic [2:0] {
    LINK_UP           = 3'd0,
    LINK_DEGRADED     = 3'd1,
    LINK_BUS_OFF      = 3'd2,
    LINK_RECOVER_WAIT = 3'd3,
    LINK_PROBE        = 3'd4
  } link_mode_t;

  // the one action code the block must ignore
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam int SETTLE_CYCLES = 10;         // queue depth plus pipeline, with margin
  localparam int HOLD_CYCLES   = 300;        // long receiver hold-off
  localparam int PHASE_ITEMS   = 220;
  localparam int LIMIT_CYCLES  = 2_000_000;

  // one event waiting to be offered on the input channel
  typedef struct {
    logic [1:0]                    kind;
    logic [clh_pkg::TICK_BITS-1:0] stamp;
    logic                          bus_off;
    logic                          err_passive;
  } can_event_t;

  // what one poll should report
  typedef struct {
    logic [2:0]                     mode;
    logic                           tx;
    logic                           release_pulse;
    logic [clh_pkg::COUNT_BITS-1:0] bus_off_total;
    logic [clh_pkg::COUNT_BITS-1:0] err_passive_total;
    logic [2:0]                     step;
  } poll_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [1:0]                     cfg_index = '0;
  logic [clh_pkg::CFG_BITS-1:0]   cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     action = '0;
  logic [clh_pkg::TICK_BITS-1:0]  tick = '0;
  logic                           bus_off_event = 1'b0;
  logic                           err_passive_event = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [2:0]                     link_state;
  logic                           tx_enable;
  logic                           release_init;
  logic [clh_pkg::COUNT_BITS-1:0] bus_off_total;
  logic [clh_pkg::COUNT_BITS-1:0] err_passive_total;
  logic [2:0]                     backoff_index;

  can_link_health_recovery_fsm u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .tick              (tick),
    .bus_off_event     (bus_off_event),
    .err_passive_event (err_passive_event),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .link_state        (link_state),
    .tx_enable         (tx_enable),
    .release_init      (release_init),
    .bus_off_total     (bus_off_total),
    .err_passive_total (err_passive_total),
    .backoff_index     (backoff_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // events not yet offered, and poll results not yet seen
  can_event_t   pending_events[$];
  poll_result_t expected_polls[$];

  // knobs the stimulus sets per phase
  logic send_steady  = 1'b0;   // sender offers back to back
  logic drain_steady = 1'b0;   // receiver always ready
  int   hold_requests = 0;     // bumped to ask the receiver for a long hold-off

  int error_count    = 0;
  int polls_checked  = 0;
  int frames_seen    = 0;
  int errors_seen    = 0;
  int ignored_seen   = 0;
  int releases_seen  = 0;
  int deepest_step   = 0;
  logic [7:0] modes_seen = '0;

  // ---------------------------------------------------------------------------
  // supervisor prediction: own copy of registers and state
  // ---------------------------------------------------------------------------
  logic [clh_pkg::CFG_BITS-1:0]   degraded_quiet = 16'd500;
  logic [clh_pkg::CFG_BITS-1:0]   degraded_rx    = 16'd500;
  logic [clh_pkg::CFG_BITS-1:0]   probe_rx       = 16'd50;
  logic [clh_pkg::CFG_BITS-1:0]   probe_quiet    = 16'd100;

  link_mode_t                     sup_mode = LINK_UP;
  logic                           sup_tx = 1'b0;
  logic                           latched_bus_off = 1'b0;
  logic                           latched_err_passive = 1'b0;
  logic [clh_pkg::TICK_BITS-1:0]  rx_stamp = '0;
  logic [clh_pkg::TICK_BITS-1:0]  err_stamp = '0;
  logic [clh_pkg::TICK_BITS-1:0]  retry_deadline = '0;
  logic [2:0]                     retry_step = '0;
  logic [clh_pkg::COUNT_BITS-1:0] bus_off_seen = '0;
  logic [clh_pkg::COUNT_BITS-1:0] err_passive_seen = '0;

  // recovery wait per backoff step, longest entry repeats
  function automatic logic [clh_pkg::TICK_BITS-1:0] backoff_span(input logic [2:0] step);
    logic [clh_pkg::TICK_BITS-1:0] span;
    if (step == 3'd0)      span = 25;
    else if (step == 3'd1) span = 50;
    else if (step == 3'd2) span = 100;
    else if (step == 3'd3) span = 200;
    else if (step == 3'd4) span = 500;
    else                   span = 1000;
    return span;
  endfunction

  // apply one accepted event; a poll leaves its expected result behind
  task automatic advance_supervisor(input logic [1:0] kind,
                                    input logic [clh_pkg::TICK_BITS-1:0] now,
                                    input logic bo, input logic ep);
    logic [clh_pkg::TICK_BITS-1:0] since_err;
    logic [clh_pkg::TICK_BITS-1:0] since_rx;
    logic                          pulse;
    poll_result_t                  res;
    pulse = 1'b0;
    if (kind == clh_pkg::ACT_FRAME) begin
      rx_stamp = now;
      frames_seen++;
    end else if (kind == clh_pkg::ACT_ERROR) begin
      if (bo) latched_bus_off = 1'b1;
      if (ep) latched_err_passive = 1'b1;
      errors_seen++;
    end else if (kind == clh_pkg::ACT_POLL) begin
      // latched flags first, bus-off wins over error-passive
      if (latched_bus_off) begin
        bus_off_seen++;
        err_stamp = now;
        sup_tx = 1'b0;
        sup_mode = LINK_BUS_OFF;
      end else if (latched_err_passive) begin
        err_passive_seen++;
        err_stamp = now;
        if (sup_mode == LINK_UP) sup_mode = LINK_DEGRADED;
      end
      latched_bus_off = 1'b0;
      latched_err_passive = 1'b0;
      since_err = now - err_stamp;
      since_rx = now - rx_stamp;
      // then exactly one state step
      case (sup_mode)
        LINK_UP: begin
          sup_tx = 1'b1;
        end
        LINK_DEGRADED: begin
          sup_tx = 1'b1;
          if (since_err > clh_pkg::TICK_BITS'(degraded_quiet) &&
              since_rx < clh_pkg::TICK_BITS'(degraded_rx))
            sup_mode = LINK_UP;
        end
        LINK_BUS_OFF: begin
          retry_deadline = now + backoff_span(retry_step);
          if (retry_step < clh_pkg::BACKOFF_LAST) retry_step++;
          sup_mode = LINK_RECOVER_WAIT;
        end
        LINK_RECOVER_WAIT: begin
          sup_tx = 1'b0;
          // plain compare, a wrapped deadline releases early
          if (now >= retry_deadline) begin
            pulse = 1'b1;
            sup_mode = LINK_PROBE;
            err_stamp = now;
          end
        end
        LINK_PROBE: begin
          sup_tx = 1'b0;
          if (since_rx < clh_pkg::TICK_BITS'(probe_rx) ||
              since_err > clh_pkg::TICK_BITS'(probe_quiet)) begin
            sup_mode = LINK_UP;
            sup_tx = 1'b1;
            retry_step = '0;
          end
        end
        default: ;
      endcase
      res.mode = sup_mode;
      res.tx = sup_tx;
      res.release_pulse = pulse;
      res.bus_off_total = bus_off_seen;
      res.err_passive_total = err_passive_seen;
      res.step = retry_step;
      expected_polls.push_back(res);
    end else begin
      ignored_seen++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // failure reporting
  // ---------------------------------------------------------------------------
  task automatic log_failure(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_failure($sformatf("poll %0d %s got 0x%0h want 0x%0h", polls_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // driver: pops pending events, random gaps between transfers
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (send_steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin : event_driver
    can_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      // channel free: either nothing offered or the last offer just transferred
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        action <= ev.kind;
        tick <= ev.stamp;
        bus_off_event <= ev.bus_off;
        err_passive_event <= ev.err_passive;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  int hold_served = 0;

  always @(posedge clk) begin : result_receiver
    int r;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (drain_steady) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(99);
      if (r < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, compare each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    poll_result_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        advance_supervisor(action, tick, bus_off_event, err_passive_event);
      if (out_valid && out_ready) begin
        if (expected_polls.size() == 0) begin
          log_failure("result transfer with no poll outstanding");
        end else begin
          want = expected_polls.pop_front();
          check_field("link_state", 32'(link_state), 32'(want.mode));
          check_field("tx_enable", 32'(tx_enable), 32'(want.tx));
          check_field("release_init", 32'(release_init), 32'(want.release_pulse));
          check_field("bus_off_total", bus_off_total, want.bus_off_total);
          check_field("err_passive_total", err_passive_total, want.err_passive_total);
          check_field("backoff_index", 32'(backoff_index), 32'(want.step));
          polls_checked++;
          modes_seen[link_state] = 1'b1;
          if (release_init) releases_seen++;
          if (int'(backoff_index) > deepest_step) deepest_step = int'(backoff_index);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_event(input logic [1:0] kind, input logic [clh_pkg::TICK_BITS-1:0] stamp,
                           input logic bo, input logic ep);
    can_event_t ev;
    ev.kind = kind;
    ev.stamp = stamp;
    ev.bus_off = bo;
    ev.err_passive = ep;
    pending_events.push_back(ev);
  endtask

  // block until everything offered has transferred and every poll has answered
  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || expected_polls.size() != 0)
      @(negedge clk);
    // trailing frame or error events may still sit in the block queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input clh_pkg::reg_index_t idx,
                                input logic [clh_pkg::CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      clh_pkg::REG_DEGRADED_QUIET: degraded_quiet = value;
      clh_pkg::REG_DEGRADED_RX:    degraded_rx = value;
      clh_pkg::REG_PROBE_RX:       probe_rx = value;
      clh_pkg::REG_PROBE_QUIET:    probe_quiet = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] dq, input logic [15:0] drx,
                                input logic [15:0] prx, input logic [15:0] pq);
    write_register(clh_pkg::REG_DEGRADED_QUIET, dq);
    write_register(clh_pkg::REG_DEGRADED_RX, drx);
    write_register(clh_pkg::REG_PROBE_RX, prx);
    write_register(clh_pkg::REG_PROBE_QUIET, pq);
  endtask

  // a stretch of plausible link traffic around a running tick, with some noise
  task automatic queue_session(input int count, input logic [clh_pkg::TICK_BITS-1:0] start);
    logic [clh_pkg::TICK_BITS-1:0] now_t;
    logic [1:0]                    kind;
    int                            made;
    int                            r;
    now_t = start;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 30) begin
        add_event(clh_pkg::ACT_FRAME, now_t, 1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end else if (r < 48) begin
        // mostly real fault reports, the odd empty one
        add_event(clh_pkg::ACT_ERROR, now_t, $urandom_range(99) < 40,
                  $urandom_range(99) < 55);
        made++;
      end else if (r < 94) begin
        add_event(clh_pkg::ACT_POLL, now_t, 1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end else begin
        // noise: any code, any tick
        kind = 2'($urandom_range(3));
        add_event(kind, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if (kind != ACT_RESERVED) made++;
      end
      r = $urandom_range(99);
      if (r < 60)      now_t = now_t + $urandom_range(20);
      else if (r < 90) now_t = now_t + $urandom_range(20, 200);
      else             now_t = now_t + $urandom_range(200, 1200);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    logic [clh_pkg::TICK_BITS-1:0] start_tick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk on reset register values
    add_event(clh_pkg::ACT_FRAME, 32'd0, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'd0, 1'b0, 1'b0);            // up, tx on
    add_event(clh_pkg::ACT_ERROR, 32'd5, 1'b0, 1'b0);           // error with no flag
    add_event(clh_pkg::ACT_POLL, 32'd6, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_ERROR, 32'd10, 1'b0, 1'b1);
    add_event(clh_pkg::ACT_POLL, 32'd12, 1'b0, 1'b0);           // into degraded
    add_event(clh_pkg::ACT_FRAME, 32'd600, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'd700, 1'b0, 1'b0);          // quiet long enough, back up
    add_event(clh_pkg::ACT_ERROR, 32'd800, 1'b1, 1'b1);         // bus-off beats error-passive
    add_event(clh_pkg::ACT_POLL, 32'd810, 1'b0, 1'b0);          // straight on to recover-wait
    add_event(clh_pkg::ACT_POLL, 32'd820, 1'b0, 1'b0);          // deadline not reached
    add_event(clh_pkg::ACT_POLL, 32'd835, 1'b0, 1'b0);          // release into probe
    add_event(clh_pkg::ACT_POLL, 32'd840, 1'b0, 1'b0);          // probing, no traffic yet
    add_event(clh_pkg::ACT_FRAME, 32'd850, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'd860, 1'b0, 1'b0);          // recent frame ends probe
    add_event(ACT_RESERVED, 32'd870, 1'b1, 1'b1);               // ignored code
    add_event(clh_pkg::ACT_ERROR, 32'hFFFF_FFF0, 1'b1, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'hFFFF_FFF0, 1'b0, 1'b0);    // deadline wraps past zero
    add_event(clh_pkg::ACT_POLL, 32'hFFFF_FFF1, 1'b0, 1'b0);    // non-wrap compare releases
    add_event(clh_pkg::ACT_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'd200, 1'b0, 1'b0);          // elapsed across the wrap
    add_event(clh_pkg::ACT_ERROR, 32'd300, 1'b0, 1'b1);
    add_event(clh_pkg::ACT_ERROR, 32'd301, 1'b1, 1'b0);         // flags accumulate until a poll
    add_event(clh_pkg::ACT_POLL, 32'd302, 1'b0, 1'b0);
    add_event(clh_pkg::ACT_POLL, 32'd0, 1'b0, 1'b0);            // tick behind deadline, waiting
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        3: apply_settings(16'($urandom_range(64)), 16'($urandom_range(64)),
                          16'($urandom_range(64)), 16'($urandom_range(64)));
        4: apply_settings(16'($urandom_range(1000)), 16'($urandom_range(1000)),
                          16'($urandom_range(200)), 16'($urandom_range(400)));
        default: apply_settings(16'd500, 16'd500, 16'd50, 16'd100);
      endcase
      @(negedge clk);
      // phase 1 floods the input while the receiver holds off, phase 2 runs gap free
      send_steady = (phase == 1) || (phase == 2);
      drain_steady = (phase == 2);
      if (phase == 0)      start_tick = '0;
      else if (phase == 1) start_tick = 32'hFFFF_F000 + $urandom_range(2048);
      else                 start_tick = $urandom;
      queue_session(PHASE_ITEMS, start_tick);
      if (phase == 1) hold_requests++;
      wait_idle();
    end

    $display("covered %0d polls, %0d frames, %0d error reports, %0d ignored codes",
             polls_checked, frames_seen, errors_seen, ignored_seen);
    $display("link modes seen 0x%0h, %0d recovery releases, backoff step up to %0d",
             modes_seen, releases_seen, deepest_step);
    if (error_count == 0) begin
      $display("[can_link_health_recovery_fsm] OK");
    end else begin
      $display("[can_link_health_recovery_fsm] ERROR");
    end
    $finish;
  end

  // watchdog for a stuck handshake or a missing result
  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("[can_link_health_recovery_fsm] ERROR");
    $finish;
  end

endmodule
